[sv/swm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the star-only wildcard matcher.
// No dependencies; imported by swm_cell, swm_closure and the top level.
package swm_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam int CHAR_W   = 8;
  localparam int POS_W    = 6;
  localparam int MODE_W   = 2;
  localparam int LEN_CFG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'd42;

  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUBJECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLED = 2'd1;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic step;     // advance the active set on a subject byte
    logic restart;  // return the active set to the start position
  } swm_ctrl_t;

endpackage

[sv/star_wildcard_matcher_unit.sv]
`timescale 1ns / 1ps
// Top level of the star-only wildcard matcher: chain of pattern cells,
// star closure adder and result register. Depends on swm_pkg, swm_cell, swm_closure.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | in        | in_tvalid/tready   | tuser: mode; tdata: position, char_value
//  out_    | out       | out_tvalid/tready  | tdata: matched
//  cfg_    | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// One request per cycle: every item is finished in the cycle it is accepted,
// the active set is one flip-flop per cell and the closure is a single carry add.
// An end request shows its result on out_ in the cycle after acceptance.
// in_tready falls only while a result is held and out_tready is low.
// Reset clears the active set to the start position and both registers to zero;
// the pattern bytes are not cleared. cfg_ready is always high.
module star_wildcard_matcher_unit
  import swm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  input  logic [15:0]           in_tdata,   // [5:0] position, [13:6] char_value, [15:14] zero
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] matched, [7:1] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers
  logic [LEN_CFG_W-1:0] len_r;
  logic                 filter_r;

  // Request fields
  logic                 in_acc;
  logic [MODE_W-1:0]    mode;
  logic [POS_W-1:0]     position;
  logic [CHAR_W-1:0]    char_value;

  // Active set and chain signals
  swm_ctrl_t            ctrl;
  logic [SET_W-1:0]     active;
  logic [SET_W-1:0]     prop;
  logic [SET_W-1:0]     closed;
  logic [SET_W-1:0]     adv_chain;
  logic [MAX_PATTERN-1:0] in_use;
  logic                 tail_r;
  logic                 tail_nxt;
  logic [LEN_W-1:0]     used_len;

  // Result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 matched_r;
  logic                 matched_nxt;

  assign mode       = in_tuser;
  assign position   = in_tdata[POS_W-1:0];
  assign char_value = in_tdata[POS_W+CHAR_W-1:POS_W];

  // Accept whenever the result slot is free or drains this cycle.
  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;

  // Configuration: always ready, unknown indexes dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      filter_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PATTERN_LENGTH) begin
        len_r <= cfg_data[LEN_CFG_W-1:0];
      end else if (cfg_index == REG_FILTER_ENABLED) begin
        filter_r <= cfg_data[0];
      end
    end
  end

  // Clamp an overlong length to the store depth.
  assign used_len = (32'(len_r) > 32'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_r);

  always_comb begin
    ctrl.step    = 1'b0;
    ctrl.restart = 1'b0;
    if (in_acc) begin
      unique case (mode)
        MODE_SUBJECT: ctrl.step    = 1'b1;
        MODE_END:     ctrl.restart = 1'b1;
        MODE_WRITE, MODE_UNUSED: ;
        default: ;
      endcase
    end
  end

  // Row of pattern cells; each hands its advance bit to the next one.
  assign adv_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic wr_en;

    assign in_use[i] = (32'(i) < 32'(len_r));
    assign wr_en     = in_acc & (mode == MODE_WRITE) & (32'(position) == 32'(i));

    swm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .restart_val ((i == 0) ? 1'b1 : 1'b0),
      .wr_en       (wr_en),
      .wr_byte     (char_value),
      .subj_byte   (char_value),
      .in_use      (in_use[i]),
      .closed_i    (closed[i]),
      .adv_i       (adv_chain[i]),
      .active_o    (active[i]),
      .star_o      (prop[i]),
      .adv_o       (adv_chain[i+1])
    );
  end

  // Position one past the last pattern byte: reached only by advancing.
  always_comb begin
    tail_nxt = tail_r;
    if (ctrl.restart) begin
      tail_nxt = 1'b0;
    end else if (ctrl.step) begin
      tail_nxt = adv_chain[MAX_PATTERN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= 1'b0;
    end else begin
      tail_r <= tail_nxt;
    end
  end

  assign active[MAX_PATTERN] = tail_r;

  // Stars only propagate inside the pattern in use; the tail never propagates.
  logic [SET_W-1:0] prop_used;
  assign prop_used = prop & {1'b0, in_use};

  swm_closure #(
    .W (SET_W)
  ) u_closure (
    .active (active),
    .prop   (prop_used),
    .closed (closed)
  );

  // Result: load on an end request, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    matched_nxt   = matched_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.restart) begin
      out_valid_nxt = 1'b1;
      matched_nxt   = ~filter_r | closed[used_len];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, matched_r};

  // prop bit of the tail is unused by design; keep it defined.
  assign prop[MAX_PATTERN] = 1'b0;

endmodule

[sv/swm_cell.sv]
`timescale 1ns / 1ps
// One pattern position: stored pattern byte plus its active bit.
// Depends on swm_pkg.
module swm_cell
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  swm_ctrl_t         ctrl,
  input  logic              restart_val,  // active value after reset or restart
  input  logic              wr_en,
  input  logic [CHAR_W-1:0] wr_byte,
  input  logic [CHAR_W-1:0] subj_byte,
  input  logic              in_use,       // position lies below the pattern length
  input  logic              closed_i,     // active bit after star closure
  input  logic              adv_i,        // advance from the left neighbor
  output logic              active_o,
  output logic              star_o,
  output logic              adv_o         // advance into the right neighbor
);

  logic [CHAR_W-1:0] byte_r;
  logic              active_r;
  logic              active_nxt;
  logic              keep;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= wr_byte;
    end
  end

  assign star_o = (byte_r == STAR_CHAR);
  assign keep   = closed_i & in_use & star_o;
  assign adv_o  = closed_i & in_use & ~star_o & (byte_r == subj_byte);

  always_comb begin
    active_nxt = active_r;
    if (ctrl.restart) begin
      active_nxt = restart_val;
    end else if (ctrl.step) begin
      active_nxt = keep | adv_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= restart_val;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign active_o = active_r;

endmodule

[sv/swm_closure.sv]
`timescale 1ns / 1ps
// Closure of the active set over runs of stars, done as one carry chain.
// Depends on swm_pkg for the default set width.
module swm_closure
  import swm_pkg::*;
#(
  parameter int W = MAX_PATTERN_DEF + 1
) (
  input  logic [W-1:0] active,
  input  logic [W-1:0] prop,    // star at a position in use
  output logic [W-1:0] closed
);

  logic [W-1:0] starts;
  logic [W-1:0] sum;

  // A start bit on a star carries through the star run and lands one past it.
  assign starts = active & prop;
  assign sum    = prop + starts;
  assign closed = active | (sum ^ prop);

endmodule

[test/swm_match_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for star_wildcard_matcher_unit: mirrors pattern bytes, registers and the
// active position set, predicts each end-of-subject result and checks out_ against it.
// Depends on swm_pkg; instantiated by testbench beside the DUT.
module swm_match_checker
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic [15:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_matches
);

  localparam int NPOS = MAX_PATTERN_DEF;
  localparam logic [NPOS:0] START_SET = {{NPOS{1'b0}}, 1'b1};

  logic [CHAR_W-1:0]    pat_mirror [NPOS];
  logic [NPOS:0]        live_set;
  logic [LEN_CFG_W-1:0] len_reg;
  logic                 filter_on;
  logic                 due_matches [$];

  function automatic int span();
    return (len_reg > LEN_CFG_W'(NPOS)) ? NPOS : int'(len_reg);
  endfunction

  // A live position sitting on a star also makes the next position live.
  function automatic logic [NPOS:0] star_closure(logic [NPOS:0] s);
    int n;
    n = span();
    for (int i = 0; i < n; i++)
      if (s[i] && pat_mirror[i] == STAR_CHAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic logic [NPOS:0] advance_set(logic [CHAR_W-1:0] ch);
    logic [NPOS:0] cur;
    logic [NPOS:0] nxt;
    int n;
    cur = star_closure(live_set);
    nxt = '0;
    n = span();
    for (int i = 0; i < n; i++) begin
      if (cur[i]) begin
        if (pat_mirror[i] == STAR_CHAR) nxt[i] = 1'b1;
        else if (pat_mirror[i] == ch) nxt[i+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  function automatic logic subject_matched();
    logic [NPOS:0] cur;
    cur = star_closure(live_set);
    return filter_on ? cur[span()] : 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    logic want;
    logic [POS_W-1:0] pos;
    logic [CHAR_W-1:0] ch;
    if (!rst_n) begin
      live_set = START_SET;
      len_reg = '0;
      filter_on = 1'b0;
      due_matches.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_matches.size() == 0) begin
          flag_mismatch("result with no end request pending", -1, int'(out_tdata[0]));
        end else begin
          want = due_matches.pop_front();
          if (out_tdata[0] !== want) flag_mismatch("matched", int'(want), int'(out_tdata[0]));
        end
      end
      if (in_tvalid && in_tready) begin
        pos = in_tdata[POS_W-1:0];
        ch = in_tdata[POS_W +: CHAR_W];
        case (in_tuser)
          MODE_WRITE:   pat_mirror[pos] = ch;
          MODE_SUBJECT: live_set = advance_set(ch);
          MODE_END: begin
            due_matches.push_back(subject_matched());
            live_set = START_SET;
          end
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: len_reg = cfg_data;
          REG_FILTER_ENABLED: filter_on = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_matches = due_matches.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the matcher test: clock, reset, request and configuration stimulus, result
// back-pressure and the verdict. Depends on swm_pkg, star_wildcard_matcher_unit, swm_match_checker.
module testbench;
  import swm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_PHASE   = 2;
  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [MODE_W-1:0]     in_tuser;   // [1:0] mode
  logic [15:0]           in_tdata;   // [5:0] position, [13:6] char_value, [15:14] zero
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [0] matched, [7:1] zero
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int pending_matches;
  int idle_pct;      // chance in 100 that the sender skips a cycle
  int stall_pct;     // chance in 100 that the receiver drops out_tready
  bit hold_request;  // asks the receiver process for one long hold-off
  int sent_items;
  int cycle_count = 0;
  int cfg_len;       // pattern_length as last written

  // Our own copy of the pattern bytes, used only to shape subjects that match.
  logic [CHAR_W-1:0] pat_img [MAX_PATTERN_DEF];

  star_wildcard_matcher_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  swm_match_checker u_match_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_matches (pending_matches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off on request so the
  // result register fills and the block has to drop in_tready.
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one request and hold it until accepted. Entered and left just after a
  // falling edge; tvalid stays high for a back-to-back request.
  task automatic send_req(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                          logic [CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, ch, pos};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (mode != MODE_UNUSED) sent_items++;
  endtask

  task automatic put_pattern(int pos, logic [CHAR_W-1:0] ch);
    send_req(MODE_WRITE, POS_W'(pos), ch);
    pat_img[pos] = ch;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Stop offering requests, wait for every predicted result, then let the block
  // go quiet before touching registers.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_matches != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers; the filter write carries random upper bits, and now and
  // then a write to an unused index follows.
  task automatic configure(int len, bit filt);
    logic [CFG_DATA_W-1:0] fval;
    fval = CFG_DATA_W'($urandom);
    fval[0] = filt;
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_FILTER_ENABLED, fval);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cfg_len = len;
  endtask

  // Mostly a small alphabet so matches happen, sometimes any byte.
  function automatic logic [CHAR_W-1:0] common_char();
    case ($urandom_range(0, 4))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char();
    return ($urandom_range(0, 3) == 0) ? STAR_CHAR : common_char();
  endfunction

  task automatic load_pattern(int n);
    for (int i = 0; i < n; i++) put_pattern(i, pattern_char());
  endtask

  // Build a subject that fits the pattern in use (stars take zero to three bytes),
  // break it now and then, and stream it with an end request. Sprinkle ignored
  // requests and the odd pattern rewrite in the middle.
  task automatic run_subject();
    logic [CHAR_W-1:0] text [$];
    int n;
    n = (cfg_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : cfg_len;
    for (int i = 0; i < n; i++) begin
      if (pat_img[i] == STAR_CHAR) repeat ($urandom_range(0, 3)) text.push_back(common_char());
      else text.push_back(pat_img[i]);
    end
    case ($urandom_range(0, 9))
      6: if (text.size() > 0) text[$urandom_range(0, text.size() - 1)] = common_char();
      7: if (text.size() > 0) text.delete($urandom_range(0, text.size() - 1));
      8: text.insert($urandom_range(0, text.size()), common_char());
      9: text.push_back(common_char());
      default: ;
    endcase
    foreach (text[i]) begin
      if ($urandom_range(0, 49) == 0)
        send_req(MODE_UNUSED, POS_W'($urandom), CHAR_W'($urandom));
      if ($urandom_range(0, 79) == 0)
        put_pattern($urandom_range(0, MAX_PATTERN_DEF - 1), pattern_char());
      send_req(MODE_SUBJECT, POS_W'($urandom), text[i]);
    end
    send_req(MODE_END, POS_W'($urandom), CHAR_W'($urandom));
  endtask

  initial begin
    int len;
    int base;
    int phase;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    sent_items   = 0;
    cfg_len      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Filter off after reset: an empty subject and a one-byte subject both match.
    send_req(MODE_END, '0, '0);
    send_req(MODE_SUBJECT, 6'h3F, 8'h61);
    send_req(MODE_END, '0, '0);

    // Fill the whole store first so no length ever reaches an unwritten byte.
    load_pattern(MAX_PATTERN_DEF);
    put_pattern(MAX_PATTERN_DEF - 1, 8'hFF);

    // Empty pattern with the filter on: only an empty subject matches.
    settle();
    configure(0, 1'b1);
    send_req(MODE_END, '0, '0);
    send_req(MODE_SUBJECT, '0, 8'h00);
    send_req(MODE_END, '0, '0);

    // Stars only: the empty subject matches, so does anything else.
    put_pattern(0, STAR_CHAR);
    put_pattern(1, STAR_CHAR);
    settle();
    configure(2, 1'b1);
    send_req(MODE_END, '0, '0);
    send_req(MODE_SUBJECT, '0, 8'hFF);
    send_req(MODE_END, '0, '0);

    // Literal, star, zero byte: zero is an ordinary literal.
    put_pattern(0, 8'h61);
    put_pattern(1, STAR_CHAR);
    put_pattern(2, 8'h00);
    settle();
    configure(3, 1'b1);
    send_req(MODE_SUBJECT, '0, 8'h61);
    send_req(MODE_SUBJECT, '0, 8'h00);
    send_req(MODE_END, '0, '0);
    send_req(MODE_SUBJECT, '0, 8'h61);
    send_req(MODE_UNUSED, 6'h3F, 8'hFF);
    send_req(MODE_SUBJECT, '0, STAR_CHAR);
    send_req(MODE_END, '0, '0);

    // Overlong length clamps to the full store; then full length with filter off.
    settle();
    configure(127, 1'b1);
    run_subject();
    settle();
    configure(MAX_PATTERN_DEF, 1'b0);
    run_subject();

    // Random phases: new registers, often a new pattern, then a batch of subjects.
    base = sent_items;
    phase = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      settle();
      case (phase % 5)
        1:       begin idle_pct = 64; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 64; end
        3:       begin idle_pct = 8;  stall_pct = 8;  end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      case ($urandom_range(0, 19))
        0, 1:    len = MAX_PATTERN_DEF;
        2:       len = $urandom_range(MAX_PATTERN_DEF + 1, 127);
        3, 4, 5: len = $urandom_range(9, 24);
        default: len = $urandom_range(0, 8);
      endcase
      if (phase == HOLD_PHASE) len = 3;
      configure(len, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 2) != 0)
        load_pattern((len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len);
      if (phase == HOLD_PHASE) begin
        // Keep the sender busy while the receiver holds off.
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        repeat (16) run_subject();
      end else begin
        repeat ($urandom_range(3, 8)) run_subject();
      end
      phase++;
    end

    settle();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && pending_matches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
